[sv/rid_pkg.sv]
package rid_pkg;

  localparam int BUCKETS  = 1024;
  localparam int WAYS     = 4;
  localparam int SLOTS    = BUCKETS * WAYS;

  localparam int ID_W     = 22;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;
  localparam int ACT_W    = 2;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int WAY_CW   = $clog2(WAYS + 1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(0);

  localparam logic [ACT_W-1:0] ACT_SUPPRESS = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_REFRESH  = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_INSERT   = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_EVICT    = ACT_W'(3);

  typedef struct packed {
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic             is_recent;
    logic [ACT_W-1:0] action;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

  typedef struct packed {
    logic [TIME_W-1:0] age;
    logic              below_window;
    logic              older;
  } age_res_t;

endpackage

[sv/rid_table.sv]
module rid_table (
  input  logic                        clk,
  input  rid_pkg::tbl_wr_t            wr,
  input  logic [rid_pkg::SLOT_W-1:0]  rd_addr,
  output rid_pkg::entry_t             rd_data
);
  import rid_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/rid_age_unit.sv]
module rid_age_unit (
  input  logic [rid_pkg::TIME_W-1:0] now_seconds,
  input  logic [rid_pkg::TIME_W-1:0] stamp,
  input  logic [rid_pkg::WIN_W-1:0]  window,
  input  logic [rid_pkg::TIME_W-1:0] old_age,
  output rid_pkg::age_res_t          res
);
  import rid_pkg::*;

  logic [TIME_W-1:0] age;

  // age wraps modulo 2^32, so a stamp ahead of now looks very old
  assign age              = now_seconds - stamp;
  assign res.age          = age;
  assign res.below_window = age < TIME_W'(window);
  assign res.older        = age > old_age;

endmodule

[sv/rid_ctrl.sv]
module rid_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rid_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rid_pkg::out_item_t          out_item,
  input  logic [rid_pkg::WIN_W-1:0]   window,
  output rid_pkg::tbl_wr_t            tbl_wr,
  output logic [rid_pkg::SLOT_W-1:0]  rd_addr,
  input  rid_pkg::entry_t             rd_data
);
  import rid_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t             state;
  logic [SLOT_W-1:0]  clr_addr;
  logic [ID_W-1:0]    id_reg;
  logic [TIME_W-1:0]  now_reg;
  logic [WAY_CW-1:0]  cnt;
  logic               have_hit;
  logic               hit_recent;
  logic [WAY_CW-1:0]  hit_way;
  logic               have_free;
  logic [WAY_CW-1:0]  free_way;
  logic               have_old;
  logic [WAY_CW-1:0]  old_way;
  logic [TIME_W-1:0]  old_age;

  logic [BUCKET_W-1:0] bucket;
  logic [SLOT_W-1:0]   base;
  logic [WAY_CW-1:0]   eval_way;
  logic [WAY_CW-1:0]   wr_way;
  logic                hit;
  logic [ACT_W-1:0]    act;
  age_res_t            age_res;

  rid_age_unit u_age (
    .now_seconds (now_reg),
    .stamp       (rd_data.stamp),
    .window      (window),
    .old_age     (old_age),
    .res         (age_res)
  );

  assign bucket   = BUCKET_W'(id_reg % ID_W'(BUCKETS));
  assign base     = SLOT_W'(bucket) * SLOT_W'(WAYS);
  assign rd_addr  = base + SLOT_W'(cnt);
  assign eval_way = cnt - WAY_CW'(1);
  assign hit      = rd_data.valid && (rd_data.id == id_reg);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    priority if (have_hit) begin
      wr_way = hit_way;
      act    = hit_recent ? ACT_SUPPRESS : ACT_REFRESH;
    end else if (have_free) begin
      wr_way = free_way;
      act    = ACT_INSERT;
    end else begin
      wr_way = old_way;
      act    = ACT_EVICT;
    end
  end

  always_comb begin
    tbl_wr = '0;
    if (state == ST_CLEAR) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = clr_addr;
    end else if (state == ST_WRITE) begin
      tbl_wr.en         = !(have_hit && hit_recent);
      tbl_wr.addr       = base + SLOT_W'(wr_way);
      tbl_wr.data.valid = 1'b1;
      tbl_wr.data.id    = id_reg;
      tbl_wr.data.stamp = now_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // ST_DONE loads the output register itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            id_reg    <= in_item.process_id;
            now_reg   <= in_item.now_seconds;
            cnt       <= '0;
            have_hit  <= 1'b0;
            have_free <= 1'b0;
            have_old  <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue way cnt, judge way cnt-1 whose data has just come back
          cnt <= cnt + WAY_CW'(1);
          if (cnt != '0 && !have_hit) begin
            priority if (hit) begin
              have_hit   <= 1'b1;
              hit_recent <= age_res.below_window;
              hit_way    <= eval_way;
            end else if (!rd_data.valid) begin
              if (!have_free) begin
                have_free <= 1'b1;
                free_way  <= eval_way;
              end
            end else begin
              if (!have_old || age_res.older) begin
                have_old <= 1'b1;
                old_age  <= age_res.age;
                old_way  <= eval_way;
              end
            end
          end
          if (cnt == WAY_CW'(WAYS)) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_item.is_recent <= have_hit && hit_recent;
            out_item.action    <= act;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_suppress_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && have_hit && hit_recent) |-> !tbl_wr.en)
    else $error("suppressed item wrote the table");

  a_recent_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.is_recent == (out_item.action == ACT_SUPPRESS)))
    else $error("is_recent disagrees with action");

  a_full_has_victim: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !have_hit && !have_free) |-> have_old)
    else $error("full bucket without an eviction candidate");

endmodule

[sv/recent_id_dedup_filter.sv]
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  process_id, now_seconds
// out       output     out_valid/out_stall is_recent, action
// cfg       APB        psel/penable/pready window_seconds at byte address 0
//
// One item is handled at a time: the ways of its bucket are read
// one per cycle from a table with one read port and judged by one shared age/compare unit.
// After reset the table's valid marks are cleared, one entry a cycle, through all
// BUCKETS*WAYS entries (4096); in_stall stays high until then.
// A finished item waits in the output register; a new item is taken meanwhile.
module recent_id_dedup_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rid_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rid_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rid_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rid_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rid_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rid_pkg::*;

  logic [WIN_W-1:0]     window;
  logic [REG_IDX_W-1:0] reg_idx;
  tbl_wr_t              tbl_wr;
  logic [SLOT_W-1:0]    rd_addr;
  entry_t               rd_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign prdata  = (reg_idx == REG_WINDOW) ? APB_DATA_W'(window) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_WINDOW) begin
      window <= pwdata[WIN_W-1:0];
    end
  end

  rid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .window    (window),
    .tbl_wr    (tbl_wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  rid_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
